FILE: hdl/archive_keystream_xor_decrypt_top_defines.svh
// assertion macros shared by the keystream decrypt checker
// no dependencies; expects clk and rst_n in the including scope
`ifndef ARCHIVE_KEYSTREAM_XOR_DECRYPT_TOP_DEFINES_SVH
`define ARCHIVE_KEYSTREAM_XOR_DECRYPT_TOP_DEFINES_SVH

// general clocked property, disabled in reset
`define AKXD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("akxd property violated");

// a stalled channel keeps valid and payload until taken
`define AKXD_ASSERT_HOLD(lbl, vld, rdy, dat) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(dat))) \
        else $error("akxd stalled request changed");

`endif

FILE: hdl/akxd_pkg.sv
// types, constants and keystream functions for the keystream decrypt block
// no dependencies
package akxd_pkg;

    localparam logic [31:0] KEY_DEFAULT = 32'h0006_7895;
    localparam logic [31:0] SEED_SUB    = 32'h579E_2B8D;
    localparam logic [31:0] BYTE_SUB    = 32'h0000_0049;
    localparam logic [31:0] RUN_SUB     = 32'h1563_3649;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       end_mark;
    } out_item_t;

    // key-derived values handed from the key schedule to the datapath
    typedef struct packed {
        logic        reload;
        logic [31:0] seed;
        logic [31:0] step;
    } key_sched_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
        return 32'($signed(x) >>> sh);
    endfunction

    function automatic logic [31:0] eff_key(input logic [31:0] k);
        return (k == 32'h0) ? KEY_DEFAULT : k;
    endfunction

    function automatic logic [31:0] seed_of(input logic [31:0] k);
        logic [31:0] e;
        e = eff_key(k);
        return (asr32(e, 12) ^ (e << 18)) - SEED_SUB;
    endfunction

    function automatic logic [31:0] step_of(input logic [31:0] k);
        logic [31:0] e;
        e = eff_key(k);
        return asr32(e, 10) ^ (e << 14);
    endfunction

    localparam logic [31:0] SEED_RESET = seed_of(32'h0);
    localparam logic [31:0] STEP_RESET = step_of(32'h0);

endpackage

FILE: hdl/akxd_keysched.sv
// key register stage: turns a key write into seed and step words
// depends on akxd_pkg
module akxd_keysched (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [31:0]       cfg_data,
    output akxd_pkg::key_sched_t     sched
);

    logic        seed_reg;
    logic [31:0] seed_val_reg;
    logic [31:0] step_reg;
    logic        cfg_take;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= 1'b0;
            seed_val_reg <= akxd_pkg::SEED_RESET;
            step_reg     <= akxd_pkg::STEP_RESET;
        end
        else
        begin
            seed_reg <= cfg_take;
            if (cfg_take)
            begin
                seed_val_reg <= akxd_pkg::seed_of(cfg_data);
                step_reg     <= akxd_pkg::step_of(cfg_data);
            end
        end
    end

    assign sched.reload = seed_reg;
    assign sched.seed   = seed_val_reg;
    assign sched.step   = step_reg;

endmodule

FILE: hdl/akxd_core.sv
// datapath: input register, keystream update, result register
// depends on akxd_pkg
module akxd_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  akxd_pkg::key_sched_t     sched,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  akxd_pkg::in_item_t       in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output akxd_pkg::out_item_t      out_data
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    akxd_pkg::in_item_t   s1_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    akxd_pkg::out_item_t  out_data_reg;
    akxd_pkg::out_item_t  out_data_next;
    logic [31:0]          run_reg;
    logic [31:0]          run_next;

    logic                 in_take;
    logic                 s1_adv;
    logic [31:0]          next_word;
    logic [31:0]          run_asr;
    logic [31:0]          ks_word;
    logic [31:0]          run_step;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    // keystream arithmetic, all mod 2^32
    assign next_word = run_reg + sched.step;
    assign run_asr   = akxd_pkg::asr32(run_reg, 12);
    assign ks_word   = next_word - akxd_pkg::BYTE_SUB + run_asr;
    assign run_step  = next_word - akxd_pkg::RUN_SUB + (run_asr ^ (run_reg << 18));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        out_data_next.plain_byte = s1_data_reg.data_byte ^ ks_word[7:0];
        out_data_next.end_mark   = s1_data_reg.buffer_end;

        run_next = run_reg;
        if (sched.reload)
            run_next = sched.seed;
        else if (s1_adv)
            run_next = s1_data_reg.buffer_end ? sched.seed : run_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_reg       <= akxd_pkg::SEED_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            run_reg       <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (s1_adv)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/archive_keystream_xor_decrypt_top.sv
// Byte-stream XOR decrypter with a 32-bit running keystream word. Each input
// request carries one byte and a buffer-end flag; each produces exactly one
// output request with the decrypted byte and the same flag. A new byte can be
// taken every cycle unless the output stalls; each byte passes the input
// register, then the result register, with the single add/xor pass on the
// running word between them. Writing the key (zero selects the built-in
// default) reseeds the word via the registered reload strobe; the word also
// reseeds after every byte flagged as buffer end and after reset. Key writes
// are accepted at any time and must only be issued while the block is idle.
// depends on akxd_pkg, akxd_keysched, akxd_core
module archive_keystream_xor_decrypt_top (
    input  logic                   clk,
    input  logic                   rst_n,
    // key write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic signed [31:0]     cfg_data,
    // obfuscated byte requests
    input  logic                   in_valid,
    output logic                   in_ready,
    input  akxd_pkg::in_item_t     in_data,
    // decrypted byte requests
    output logic                   out_valid,
    input  logic                   out_ready,
    output akxd_pkg::out_item_t    out_data
);

    // seed and per-byte step words, plus reseed strobe after a key write
    akxd_pkg::key_sched_t sched;

    akxd_keysched u_keysched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sched     (sched)
    );

    // two-register datapath holding the running keystream word
    akxd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched     (sched),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hdl/akxd_checker.sv
// port-level checks for the keystream decrypt top, attached by bind
// depends on akxd_pkg and the shared assertion macro header
`include "archive_keystream_xor_decrypt_top_defines.svh"

module akxd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input akxd_pkg::out_item_t   out_data
);

    // input only backs up when both stages are full and output is stalled
    `AKXD_ASSERT(a_ready_only_on_stall, (!in_ready |-> (out_valid && !out_ready)))

    // after an accepted byte, out_valid must be high once the input and result registers are passed
    `AKXD_ASSERT(a_accept_reaches_out, ((in_valid && in_ready) |-> ##2 out_valid))

    `AKXD_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data)

endmodule

bind archive_keystream_xor_decrypt_top akxd_checker u_akxd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
